@@ design/lpht_pkg.sv @@
// shared types and codes for the linear probe hash table
`default_nettype none
package lpht_pkg;
	localparam int SLOTS_DEFAULT = 1024;
	localparam int MAX_W = 10;
	localparam logic [MAX_W-1:0] MAX_RESET = 10'd512;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_FIND   = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic        used;
		logic [63:0] key;
		logic [31:0] value;
	} slot_t;
endpackage
`default_nettype wire

@@ design/lpht_hash.sv @@
// iterative 64-to-32 shift hash, one step per cycle
`default_nettype none
module lpht_hash (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] key,
	output logic        done,
	output logic [31:0] hash
);
	localparam logic [2:0] STEP_NOT  = 3'd0;
	localparam logic [2:0] STEP_X31  = 3'd1;
	localparam logic [2:0] STEP_M21  = 3'd2;
	localparam logic [2:0] STEP_X11  = 3'd3;
	localparam logic [2:0] STEP_M65  = 3'd4;
	localparam logic [2:0] STEP_LAST = 3'd5;

	logic [63:0] k_q;
	logic [63:0] k_nxt;
	logic [2:0]  step_q;
	logic        run_q;
	logic        done_q;

	always_comb begin
		unique case (step_q)
			STEP_NOT: k_nxt = ~k_q + (k_q << 18);
			STEP_X31: k_nxt = k_q ^ (k_q >> 31);
			STEP_M21: k_nxt = k_q + (k_q << 2) + (k_q << 4);
			STEP_X11: k_nxt = k_q ^ (k_q >> 11);
			STEP_M65: k_nxt = k_q + (k_q << 6);
			default:  k_nxt = k_q ^ (k_q >> 22);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_NOT;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				k_q    <= key;
				step_q <= STEP_NOT;
				run_q  <= 1'b1;
			end else if (run_q) begin
				k_q    <= k_nxt;
				step_q <= step_q + 3'd1;
				if (step_q == STEP_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign hash = k_q[31:0];
endmodule
`default_nettype wire

@@ design/lpht_table.sv @@
// slot memory: one write port, one read port with registered data
`default_nettype none
module lpht_table #(
	parameter int ADDR_W = 10
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [ADDR_W-1:0]         waddr,
	input  wire  lpht_pkg::slot_t     wdata,
	input  wire  [ADDR_W-1:0]         raddr,
	output lpht_pkg::slot_t           rdata
);
	import lpht_pkg::*;

	slot_t mem [2**ADDR_W];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ design/linear_probe_hash_table.sv @@
// top level: sequencer for insert, find and delete over the slot memory
// After reset the block sweeps the slot memory once to mark every slot empty, with busy
// high; configuration writes are taken during that sweep. An operation starts with a start
// beat while busy is low and ends with a one-cycle done strobe carrying status, found_index
// and stored_count; the receiver cannot stall it. Every hash runs in the shared iterative
// hash unit and every slot visited is read through the registered memory read. Delete also
// reads each slot in the rest of its cluster, the empty slot that ends it included, and
// hashes and probes again for each entry it places again. A refused insert or an unused
// mode is answered from the idle state without a hash.
// SLOTS must be a power of two; the home slot is the low bits of the hash.
`default_nettype none
module linear_probe_hash_table #(
	parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  mode,
	input  wire  [31:0] key_x,
	input  wire  [31:0] key_y,
	input  wire  [31:0] edge_index,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_index,
	output logic [10:0] stored_count,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [9:0]  cfg_data
);
	import lpht_pkg::*;

	localparam int IW = $clog2(SLOTS);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_JRD  = 3'd5;
	localparam logic [2:0] S_JCHK = 3'd6;

	logic [2:0]       state_q;
	logic [IW-1:0]    clr_q;
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    j_q;
	logic [IW-1:0]    cnt_q;
	logic [MAX_W-1:0] max_q;
	logic [1:0]       mode_q;
	logic             repl_q;
	logic [63:0]      key_q;
	logic [31:0]      val_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic [31:0]      found_q;

	logic             accept;
	logic             full;
	logic             placing;
	logic             hit;
	logic             hash_start;
	logic [63:0]      hash_key;
	logic             hash_done;
	logic [31:0]      hash_val;
	logic             we;
	logic [IW-1:0]    waddr;
	slot_t            wdata;
	logic [IW-1:0]    raddr;
	slot_t            rd;

	assign accept  = start && !busy;
	assign full    = (32'(cnt_q) >= 32'(max_q)) || (32'(cnt_q) >= 32'(SLOTS - 1));
	assign placing = (mode_q == MODE_INSERT) || repl_q;
	assign hit     = rd.used && (rd.key == key_q);

	always_comb begin
		hash_start = 1'b0;
		hash_key   = {key_x, key_y};
		if (state_q == S_IDLE && accept) begin
			hash_start = (mode == MODE_FIND) || (mode == MODE_DELETE)
				|| ((mode == MODE_INSERT) && !full);
		end else if (state_q == S_JCHK && rd.used) begin
			hash_start = 1'b1;
			hash_key   = rd.key;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rd;
		raddr = (state_q == S_JRD) ? j_q : idx_q;
		unique case (state_q)
			S_CLR: begin
				we         = 1'b1;
				waddr      = clr_q;
				wdata.used = 1'b0;
			end
			S_CHK: begin
				if (placing && !rd.used) begin
					we    = 1'b1;
					wdata = '{used: 1'b1, key: key_q, value: val_q};
				end else if (!placing && mode_q == MODE_DELETE && hit) begin
					we         = 1'b1;
					wdata.used = 1'b0;
				end
			end
			S_JCHK: begin
				we         = rd.used;
				waddr      = j_q;
				wdata.used = 1'b0;
			end
			default: we = 1'b0;
		endcase
	end

	lpht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (hash_key),
		.done   (hash_done),
		.hash   (hash_val)
	);

	lpht_table #(.ADDR_W(IW)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			idx_q    <= '0;
			j_q      <= '0;
			cnt_q    <= '0;
			max_q    <= MAX_RESET;
			mode_q   <= MODE_INSERT;
			repl_q   <= 1'b0;
			key_q    <= '0;
			val_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			found_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q  <= mode;
						key_q   <= {key_x, key_y};
						val_q   <= edge_index;
						repl_q  <= 1'b0;
						found_q <= '0;
						if (hash_start) begin
							state_q <= S_HASH;
						end else begin
							// refused insert or unused mode answers at once
							done_q   <= 1'b1;
							status_q <= (mode == MODE_INSERT) ? ST_FULL : ST_OK;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						idx_q   <= hash_val[IW-1:0];
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (placing && !rd.used) begin
						if (repl_q) begin
							j_q     <= j_q + 1'b1;
							state_q <= S_JRD;
						end else begin
							cnt_q    <= cnt_q + 1'b1;
							done_q   <= 1'b1;
							status_q <= ST_OK;
							state_q  <= S_IDLE;
						end
					end else if (!placing && !rd.used) begin
						done_q   <= 1'b1;
						status_q <= ST_ABSENT;
						state_q  <= S_IDLE;
					end else if (!placing && hit) begin
						if (mode_q == MODE_DELETE) begin
							j_q     <= idx_q + 1'b1;
							state_q <= S_JRD;
						end else begin
							found_q  <= rd.value;
							done_q   <= 1'b1;
							status_q <= ST_OK;
							state_q  <= S_IDLE;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_JRD: state_q <= S_JCHK;
				S_JCHK: begin
					if (rd.used) begin
						// take the entry out and place it again from its home slot
						key_q   <= rd.key;
						val_q   <= rd.value;
						repl_q  <= 1'b1;
						state_q <= S_HASH;
					end else begin
						cnt_q    <= cnt_q - 1'b1;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign status       = status_q;
	assign found_index  = found_q;
	assign stored_count = 11'(cnt_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(SLOTS - 1))
		else $error("entry count above table capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while an operation is running");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> $stable(cnt_q))
		else $error("refused insert changed the count");

	a_found_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> found_q == '0)
		else $error("value reported with a failing status");
endmodule
`default_nettype wire
